>>> rtl/mmf_pkg.sv
package mmf_pkg;

    // Capacity of the data set and the widths that follow from it.
    localparam int MAX_ITEMS   = 64;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

    // Fixed field widths of the streams.
    localparam int VALUE_W     = 32;
    localparam int FREQ_W      = 7;
    localparam int OUT_TDATA_W = ((VALUE_W + FREQ_W + 7) / 8) * 8;

    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [VALUE_W-1:0] value_t;

    // Which index drives the store's read address.
    typedef enum logic [1:0] {
        RD_OUTER = 2'd0,
        RD_INNER = 2'd1,
        RD_SCAN  = 2'd2
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    sort_init;
        logic    hold;
        logic    put_held;
        logic    shift;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_init;
        logic    best_step;
        logic    emit_step;
        logic    clear_set;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sort_done;
        logic b_zero;
        logic greater;
        logic scan_last;
        logic emit_hit;
        logic out_free;
    } status_t;

endpackage

>>> rtl/mmf_ram.sv
module mmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mmf_datapath.sv
module mmf_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mmf_pkg::cmd_t        cmd,
    output mmf_pkg::status_t     status,
    input  mmf_pkg::value_t      in_value,
    output logic                 out_valid,
    output mmf_pkg::value_t      out_value,
    output logic [mmf_pkg::FREQ_W-1:0] out_freq,
    output logic                 out_last,
    output logic                 out_ovf,
    input  logic                 out_ready
);

    // Set bookkeeping.
    mmf_pkg::cnt_t   count_reg;
    logic            ovf_reg;

    // Sort and scan indexes and working values.
    mmf_pkg::cnt_t   a_reg;
    mmf_pkg::cnt_t   b_reg;
    mmf_pkg::cnt_t   i_reg;
    mmf_pkg::value_t held_reg;
    mmf_pkg::value_t prev_reg;
    mmf_pkg::cnt_t   run_reg;
    mmf_pkg::cnt_t   best_reg;
    mmf_pkg::cnt_t   modes_reg;
    mmf_pkg::cnt_t   run_next;

    // Output register.
    logic                        out_valid_reg;
    mmf_pkg::value_t             out_value_reg;
    logic [mmf_pkg::FREQ_W-1:0]  out_freq_reg;
    logic                        out_last_reg;
    logic                        out_ovf_reg;
    logic                        out_load;

    // Store ports.
    logic                         ram_we;
    logic [mmf_pkg::ADDR_W-1:0]   ram_waddr;
    mmf_pkg::value_t              ram_wdata;
    logic [mmf_pkg::ADDR_W-1:0]   ram_raddr;
    mmf_pkg::value_t              ram_rdata;
    mmf_pkg::cnt_t                inner_idx;
    logic                         has_room;

    mmf_ram #(
        .WIDTH (mmf_pkg::VALUE_W),
        .DEPTH (mmf_pkg::MAX_ITEMS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign has_room  = count_reg < mmf_pkg::cnt_t'(mmf_pkg::MAX_ITEMS);
    assign inner_idx = b_reg - mmf_pkg::cnt_t'(1);

    // Run length of the element now on the read port.
    always_comb begin
        if (i_reg == '0 || ram_rdata != prev_reg) begin
            run_next = mmf_pkg::cnt_t'(1);
        end else begin
            run_next = run_reg + mmf_pkg::cnt_t'(1);
        end
    end

    // Status for the controller.
    always_comb begin
        status.sort_done = a_reg >= count_reg;
        status.b_zero    = b_reg == '0;
        status.greater   = $signed(ram_rdata) > $signed(held_reg);
        status.scan_last = i_reg == (count_reg - mmf_pkg::cnt_t'(1));
        status.emit_hit  = run_next == best_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Write port: incoming elements, or the insertion sort moves.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[mmf_pkg::ADDR_W-1:0];
        ram_wdata = in_value;
        if (cmd.load) begin
            ram_we = has_room;
        end else if (cmd.put_held) begin
            ram_we    = 1'b1;
            ram_waddr = b_reg[mmf_pkg::ADDR_W-1:0];
            ram_wdata = held_reg;
        end else if (cmd.shift) begin
            ram_we    = 1'b1;
            ram_waddr = b_reg[mmf_pkg::ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    // Read address select.
    always_comb begin
        case (cmd.rd_sel)
            mmf_pkg::RD_OUTER: ram_raddr = a_reg[mmf_pkg::ADDR_W-1:0];
            mmf_pkg::RD_INNER: ram_raddr = inner_idx[mmf_pkg::ADDR_W-1:0];
            mmf_pkg::RD_SCAN:  ram_raddr = i_reg[mmf_pkg::ADDR_W-1:0];
            default:           ram_raddr = a_reg[mmf_pkg::ADDR_W-1:0];
        endcase
    end

    // Element count and the dropped-element flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.clear_set) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (has_room) begin
                count_reg <= count_reg + mmf_pkg::cnt_t'(1);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Insertion sort indexes and the held element.
    always_ff @(posedge aclk) begin
        if (cmd.sort_init) begin
            a_reg <= mmf_pkg::cnt_t'(1);
        end else if (cmd.put_held) begin
            a_reg <= a_reg + mmf_pkg::cnt_t'(1);
        end
        if (cmd.hold) begin
            held_reg <= ram_rdata;
            b_reg    <= a_reg;
        end else if (cmd.shift) begin
            b_reg <= inner_idx;
        end
    end

    // Both scans: run tracking, longest run and number of modes.
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            i_reg     <= '0;
            best_reg  <= mmf_pkg::cnt_t'(1);
            modes_reg <= '0;
        end else begin
            if (cmd.best_step || cmd.emit_step) begin
                prev_reg <= ram_rdata;
                run_reg  <= run_next;
                i_reg    <= status.scan_last ? '0 : i_reg + mmf_pkg::cnt_t'(1);
            end
            if (cmd.best_step) begin
                if (run_next > best_reg) begin
                    best_reg  <= run_next;
                    modes_reg <= mmf_pkg::cnt_t'(1);
                end else if (run_next == best_reg) begin
                    modes_reg <= modes_reg + mmf_pkg::cnt_t'(1);
                end
            end else if (out_load) begin
                modes_reg <= modes_reg - mmf_pkg::cnt_t'(1);
            end
        end
    end

    assign out_load = cmd.emit_step && status.emit_hit;

    // Output register: a result waits here until the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= ram_rdata;
            out_freq_reg  <= mmf_pkg::FREQ_W'(best_reg);
            out_last_reg  <= modes_reg == mmf_pkg::cnt_t'(1);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_freq  = out_freq_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

>>> rtl/mmf_ctrl.sv
module mmf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_final,
    output logic               in_ready,
    input  mmf_pkg::status_t   status,
    output mmf_pkg::cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_LOAD      = 9'b000000001,
        S_SORT_RD   = 9'b000000010,
        S_SORT_HOLD = 9'b000000100,
        S_SORT_CHK  = 9'b000001000,
        S_SORT_CMP  = 9'b000010000,
        S_BEST_RD   = 9'b000100000,
        S_BEST_EV   = 9'b001000000,
        S_EMIT_RD   = 9'b010000000,
        S_EMIT_EV   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_LOAD;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = mmf_pkg::RD_OUTER;
        case (state_reg)
            S_LOAD: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_final) begin
                        cmd.sort_init = 1'b1;
                        state_next    = S_SORT_RD;
                    end
                end
            end
            S_SORT_RD: begin
                if (status.sort_done) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_BEST_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SORT_HOLD;
                end
            end
            S_SORT_HOLD: begin
                cmd.hold   = 1'b1;
                state_next = S_SORT_CHK;
            end
            S_SORT_CHK: begin
                if (status.b_zero) begin
                    cmd.put_held = 1'b1;
                    state_next   = S_SORT_RD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = mmf_pkg::RD_INNER;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                if (status.greater) begin
                    cmd.shift  = 1'b1;
                    state_next = S_SORT_CHK;
                end else begin
                    cmd.put_held = 1'b1;
                    state_next   = S_SORT_RD;
                end
            end
            S_BEST_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mmf_pkg::RD_SCAN;
                state_next = S_BEST_EV;
            end
            S_BEST_EV: begin
                cmd.best_step = 1'b1;
                state_next    = status.scan_last ? S_EMIT_RD : S_BEST_RD;
            end
            S_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = mmf_pkg::RD_SCAN;
                state_next = S_EMIT_EV;
            end
            S_EMIT_EV: begin
                // A mode waits here while the output register is full and out_ready is low.
                if (!status.emit_hit || status.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.scan_last) begin
                        cmd.clear_set = 1'b1;
                        state_next    = S_LOAD;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/multimode_finder_top.sv
// Finds every statistical mode of a set of up to 64 signed 32-bit values.
// Elements arrive one per transfer on the slave side, one per cycle while
// s_tready is high, and the transfer with s_tlast high closes the set;
// elements beyond capacity are dropped and reported through m_tuser on
// every result of that set. The closing transfer starts the work, and
// s_tready stays low until the emitting scan has passed every stored
// element, by which time the last result sits in the output register.
// The set is sorted in place by an insertion sort over one store with a
// write port and a registered read port; a scan then finds the longest
// run and a second scan emits the modes, and it waits while the master
// side stalls.
// Results come out in ascending order, each with the frequency, and the
// final result of a set carries m_tlast.
module multimode_finder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mmf_pkg::VALUE_W-1:0]         s_tdata,  // [31:0] value
    input  logic                                s_tlast,  // final_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mmf_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [31:0] mode_value,
                                                          // [38:32] frequency
    output logic                                m_tlast,  // last_result
    output logic                                m_tuser   // overflow
);

    mmf_pkg::cmd_t               cmd;
    mmf_pkg::status_t            status;
    mmf_pkg::value_t             out_value;
    logic [mmf_pkg::FREQ_W-1:0]  out_freq;

    mmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_final (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mmf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_freq  (out_freq),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser),
        .out_ready (m_tready)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign m_tdata = {
        {(mmf_pkg::OUT_TDATA_W - mmf_pkg::VALUE_W - mmf_pkg::FREQ_W){1'b0}},
        out_freq,
        out_value
    };

endmodule

>>> rtl/mmf_checker.sv
module mmf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [mmf_pkg::VALUE_W-1:0]      s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mmf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser
);

    // Leaving reset, the block is ready for a new set and holds no result.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // A stalled result holds its fields.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every result has a nonzero frequency and zero padding.
    a_freq_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[mmf_pkg::VALUE_W +: mmf_pkg::FREQ_W] != '0
            && m_tdata[mmf_pkg::OUT_TDATA_W-1] == 1'b0)
        else $error("result with zero frequency or stray padding");

    // No new set is taken while a result that is not the last is pending.
    a_no_load_mid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a result sequence");

endmodule

bind multimode_finder_top mmf_checker u_mmf_checker (.*);
